// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/core/pitf_pkg.sv =====
`default_nettype none

package pitf_pkg;

   localparam int SAMPLE_W      = 16;
   localparam int ENTRY_COUNT_W = 15;
   localparam int SCAN_FLOOR_W  = 32;
   localparam int TABLE_OFFS_W  = 32;
   localparam int CNT_W         = 16;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_INDEX_W   = 1;

   localparam int OFFSET_BITS_DEFAULT = 32;

   localparam logic [ENTRY_COUNT_W-1:0] ENTRY_COUNT_RESET = '0;
   localparam logic [SCAN_FLOOR_W-1:0]  SCAN_FLOOR_RESET  = 32'h0000_1000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ENTRY_COUNT = 1'b0,
      REG_SCAN_FLOOR  = 1'b1
   } pitf_reg_type;

   typedef struct packed {
      logic [ENTRY_COUNT_W-1:0] entry_count;
      logic [SCAN_FLOOR_W-1:0]  scan_floor;
   } pitf_cfg_type;

   typedef struct packed {
      logic                    found;
      logic [TABLE_OFFS_W-1:0] table_offset;
   } pitf_result_type;

endpackage

`default_nettype wire

// ===== rtl/core/pitf_csr.sv =====
`default_nettype none

module pitf_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_enable,
   input  wire logic [pitf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [pitf_pkg::CSR_DATA_W-1:0]  csr_data,
   output pitf_pkg::pitf_cfg_type                cfg
);
   import pitf_pkg::*;

   pitf_cfg_type cfg_ff;
   pitf_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (pitf_reg_type'(csr_index))
            REG_ENTRY_COUNT: cfg_in.entry_count = csr_data[ENTRY_COUNT_W-1:0];
            REG_SCAN_FLOOR:  cfg_in.scan_floor  = csr_data[SCAN_FLOOR_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.entry_count <= ENTRY_COUNT_RESET;
         cfg_ff.scan_floor  <= SCAN_FLOOR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pitf_scan.sv =====
`default_nettype none

module pitf_scan #(
   parameter int OFFSET_BITS = pitf_pkg::OFFSET_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 accept,
   input  wire logic signed [pitf_pkg::SAMPLE_W-1:0] sample,
   input  wire logic                                 first,
   input  wire logic                                 last,
   input  pitf_pkg::pitf_cfg_type                    cfg,
   output logic                                      res_valid,
   output pitf_pkg::pitf_result_type                 res
);
   import pitf_pkg::*;

   localparam int IDX_W = OFFSET_BITS - 1;
   localparam int CMP_W = (OFFSET_BITS > SCAN_FLOOR_W) ? OFFSET_BITS : SCAN_FLOOR_W;
   localparam logic [IDX_W-1:0] IDX_MAX = '1;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] run_ff, run_in;
   logic [CNT_W-1:0] since_ff, since_in;
   logic             done_ff, done_in;

   logic [IDX_W-1:0]        idx_cur;
   logic [CNT_W-1:0]        run_cur, since_cur, run_new, since_new, bc_cnt;
   logic                    done_cur;
   logic signed [SAMPLE_W:0] sample_ext, bc_ext;
   logic                    in_range, is_special, hit_cond, match;
   logic [IDX_W-1:0]        start_hw;
   logic [CMP_W-1:0]        start_byte;

   always_comb begin
      idx_cur    = first ? '0 : idx_ff;
      run_cur    = first ? '0 : run_ff;
      since_cur  = first ? CNT_MAX : since_ff;
      done_cur   = first ? 1'b0 : done_ff;

      sample_ext = {sample[SAMPLE_W-1], sample};
      bc_ext     = $signed({2'b00, cfg.entry_count});
      in_range   = (sample_ext >= -17'sd1) && (sample_ext < bc_ext);
      is_special = (sample == '0) || (sample == '1);
      bc_cnt     = CNT_W'(cfg.entry_count);

      if (!in_range) begin
         run_new = '0;
      end else if (run_cur == CNT_MAX) begin
         run_new = run_cur;
      end else begin
         run_new = run_cur + CNT_W'(1);
      end

      if (is_special) begin
         since_new = '0;
      end else if (since_cur == CNT_MAX) begin
         since_new = since_cur;
      end else begin
         since_new = since_cur + CNT_W'(1);
      end

      hit_cond   = (cfg.entry_count != '0) && (idx_cur != IDX_MAX) &&
                   (run_new >= bc_cnt) && (since_new < bc_cnt);
      start_hw   = idx_cur + IDX_W'(1) - IDX_W'(cfg.entry_count);
      start_byte = CMP_W'({start_hw, 1'b0});
      match      = hit_cond && (start_byte >= CMP_W'(cfg.scan_floor));

      idx_in   = idx_ff;
      run_in   = run_ff;
      since_in = since_ff;
      done_in  = done_ff;
      if (accept && !done_cur) begin
         idx_in   = (idx_cur == IDX_MAX) ? idx_cur : idx_cur + IDX_W'(1);
         run_in   = run_new;
         since_in = since_new;
         done_in  = match || last;
      end

      res_valid        = accept && !done_cur && (match || last);
      res.found        = match;
      res.table_offset = match ? start_byte[TABLE_OFFS_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         run_ff   <= '0;
         since_ff <= CNT_MAX;
         done_ff  <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         run_ff   <= run_in;
         since_ff <= since_in;
         done_ff  <= done_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/pitf_outbuf.sv =====
`default_nettype none

module pitf_outbuf (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  pitf_pkg::pitf_result_type in_data,
   output logic                      in_ready,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output pitf_pkg::pitf_result_type out_data
);
   import pitf_pkg::*;

   logic            out_valid_ff, out_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   pitf_result_type out_data_ff, out_data_in;
   pitf_result_type skid_data_ff, skid_data_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_data_in  = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/parent_index_table_finder_core.sv =====
// Channel   Ports                                    Beat
// -------   --------------------------------------   ---------------------------------
// req       req_valid/req_ready, sample/first/last   one halfword of the file
// rsp       rsp_valid/rsp_ready, found/table_offset  one result per file, at most
// csr       csr_write_enable, csr_index, csr_data    one register write
//
// One beat is taken each cycle req_ready is high; its result, if any, is registered.
// The scan counters and the window check sit between the request and the result register.
// Reset is synchronous; it restores both registers and the scan state.
// req_ready falls only when the result register and the skid stage both hold a beat.
`default_nettype none

module parent_index_table_finder_core #(
   parameter int OFFSET_BITS = pitf_pkg::OFFSET_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [pitf_pkg::SAMPLE_W-1:0] req_sample,
   input  wire logic                                 req_first,
   input  wire logic                                 req_last,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_found,
   output logic [pitf_pkg::TABLE_OFFS_W-1:0]         rsp_table_offset,
   input  wire logic                                 csr_write_enable,
   input  wire logic [pitf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [pitf_pkg::CSR_DATA_W-1:0]      csr_data
);
   import pitf_pkg::*;

   pitf_cfg_type    cfg;
   pitf_result_type res, rsp_data;
   logic            res_valid;
   logic            accept;

   assign accept = req_valid && req_ready;

   pitf_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cfg              (cfg)
   );

   pitf_scan #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .sample    (req_sample),
      .first     (req_first),
      .last      (req_last),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   pitf_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_found        = rsp_data.found;
   assign rsp_table_offset = rsp_data.table_offset;

endmodule

`default_nettype wire

// ===== rtl/core/pitf_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module pitf_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic                              rsp_found,
   input wire logic [pitf_pkg::TABLE_OFFS_W-1:0] rsp_table_offset
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_found) && $stable(rsp_table_offset))
   `ASSERT_SAME(a_not_found_zero, clock, reset, rsp_valid && !rsp_found, rsp_table_offset == '0)
   `ASSERT_SAME(a_offset_even, clock, reset, rsp_valid, !rsp_table_offset[0])
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind parent_index_table_finder_core pitf_checker u_pitf_checker (.*);

`default_nettype wire
